@@ rtl/gtam_pkg.sv @@
// ----------------------------------------------------------------------------
// gtam_pkg
// Shared types and constants for the adjacency-matrix graph traversal block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtam_pkg;

    localparam int LANES    = 16;   // row width and list depth
    localparam int VTX_W    = 4;
    localparam int CNT_W    = 5;

    typedef logic [VTX_W-1:0] t_vtx;
    typedef logic [LANES-1:0] t_row;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [1:0]       t_mode;

    localparam t_mode MODE_LOAD = 2'd0;
    localparam t_mode MODE_BFS  = 2'd1;
    localparam t_mode MODE_DFS  = 2'd2;

    // Result of one neighbor pick
    typedef struct packed {
        logic hit;
        t_vtx idx;
    } t_pick;

endpackage

`default_nettype wire

@@ rtl/gtam_rows.sv @@
// ----------------------------------------------------------------------------
// gtam_rows
// Adjacency row storage: one write port, one read port, cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gtam_rows #(
    parameter int ROWS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire gtam_pkg::t_vtx i_waddr,
    input  wire gtam_pkg::t_row i_wdata,
    input  wire gtam_pkg::t_vtx i_raddr,
    output gtam_pkg::t_row     o_rdata
);
    import gtam_pkg::*;

    localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;

    t_row r_rows [ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_rows[i] <= '0;
            end
        end else if (i_we && (int'(i_waddr) < ROWS)) begin
            r_rows[i_waddr[RAW-1:0]] <= i_wdata;
        end
    end

    // Rows beyond the storage read as empty
    assign o_rdata = (int'(i_raddr) < ROWS) ? r_rows[i_raddr[RAW-1:0]] : '0;

endmodule

`default_nettype wire

@@ rtl/gtam_pick.sv @@
// ----------------------------------------------------------------------------
// gtam_pick
// Neighbor pick: lowest unvisited in-range vertex of an adjacency row.
// ----------------------------------------------------------------------------
`default_nettype none

module gtam_pick (
    input  wire gtam_pkg::t_row i_row,
    input  wire gtam_pkg::t_row i_visited,
    input  wire gtam_pkg::t_row i_range,
    output gtam_pkg::t_pick     o_pick
);
    import gtam_pkg::*;

    t_row cand;
    t_row low;
    t_vtx idx;

    assign cand = i_row & ~i_visited & i_range;
    // Isolate the lowest set bit
    assign low  = cand & (~cand + t_row'(1));

    always_comb begin
        idx = '0;
        for (int j = 0; j < LANES; j++) begin
            if (low[j]) begin
                idx = idx | t_vtx'(j);
            end
        end
    end

    assign o_pick.hit = |cand;
    assign o_pick.idx = idx;

endmodule

`default_nettype wire

@@ rtl/graph_traversal_adjacency_matrix_top.sv @@
// ----------------------------------------------------------------------------
// graph_traversal_adjacency_matrix_top
// Breadth-first and depth-first search over a stored adjacency matrix.
// ----------------------------------------------------------------------------
// Usage: a mode-0 transfer loads one adjacency row. A mode-1 or mode-2
// transfer starts a search that streams every reached vertex in visit order,
// with tlast on the final one; the slave side is not ready until the search
// is done. One neighbor pick unit makes one decision per cycle while the
// master side does not stall a depth-first step or a breadth-first pop.
// Rows reset to zero and vertex_count to 16. A start vertex at or above the
// vertex count gives no output.
`default_nettype none

module graph_traversal_adjacency_matrix_top #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,     // vertex_count
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,    // [3:0] vertex, [19:4] row_bits, rest zero
    input  wire logic [1:0]  s_axis_tuser,    // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,    // [3:0] visited_vertex, rest zero
    output logic             m_axis_tlast
);
    import gtam_pkg::*;

    localparam int   ROWS = (MAX_VERTICES < LANES) ? MAX_VERTICES : LANES;
    localparam t_cnt CAP  = t_cnt'(ROWS);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_BFS_POP  = 3'd1;
    localparam logic [2:0] S_BFS_SCAN = 3'd2;
    localparam logic [2:0] S_DFS_STEP = 3'd3;
    localparam logic [2:0] S_FLUSH    = 3'd4;

    logic [2:0] r_state, n_state;
    t_cnt       r_vcount;
    t_row       r_visited, n_visited;
    t_vtx       r_list [LANES];       // queue for breadth-first, stack for depth-first
    t_cnt       r_head, n_head;
    t_cnt       r_tail, n_tail;       // queue tail, or stack depth
    t_vtx       r_cur, n_cur;
    logic       r_hold_valid, n_hold_valid;
    t_vtx       r_hold_vtx, n_hold_vtx;
    logic       r_out_valid, n_out_valid;
    t_vtx       r_out_vtx, n_out_vtx;
    logic       r_out_last, n_out_last;

    t_mode in_mode;
    t_vtx  in_vtx;
    t_row  in_row;
    logic  accept;
    t_cnt  n_eff;
    t_row  range_mask;
    t_vtx  top_idx;
    t_vtx  rd_sel;
    t_row  rd_row;
    t_pick pick;
    logic  out_free;
    logic  emit_ok;
    logic  emit_req;
    t_vtx  emit_vtx;
    logic  list_we;
    t_vtx  list_waddr;
    t_vtx  list_wdata;
    logic  row_we;

    assign in_mode = s_axis_tuser;
    assign in_vtx  = s_axis_tdata[3:0];
    assign in_row  = s_axis_tdata[19:4];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign n_eff = (r_vcount > CAP) ? CAP : r_vcount;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            range_mask[i] = (t_cnt'(i) < n_eff);
        end
    end

    assign top_idx = t_vtx'(r_tail - t_cnt'(1));
    assign rd_sel  = (r_state == S_DFS_STEP) ? r_list[top_idx] : r_cur;

    gtam_rows #(
        .ROWS (ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (row_we),
        .i_waddr (in_vtx),
        .i_wdata (in_row),
        .i_raddr (rd_sel),
        .o_rdata (rd_row)
    );

    gtam_pick u_pick (
        .i_row     (rd_row),
        .i_visited (r_visited),
        .i_range   (range_mask),
        .o_pick    (pick)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    // A new vertex may enter the hold stage once its old content can move out
    assign emit_ok  = !r_hold_valid || out_free;

    always_comb begin
        n_state      = r_state;
        n_visited    = r_visited;
        n_head       = r_head;
        n_tail       = r_tail;
        n_cur        = r_cur;
        n_hold_valid = r_hold_valid;
        n_hold_vtx   = r_hold_vtx;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_vtx    = r_out_vtx;
        n_out_last   = r_out_last;
        emit_req     = 1'b0;
        emit_vtx     = '0;
        list_we      = 1'b0;
        list_waddr   = r_tail[VTX_W-1:0];
        list_wdata   = '0;
        row_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        MODE_LOAD: begin
                            row_we = 1'b1;
                        end
                        MODE_BFS, MODE_DFS: begin
                            if ({1'b0, in_vtx} < n_eff) begin
                                n_visited  = t_row'(1) << in_vtx;
                                list_we    = 1'b1;
                                list_waddr = '0;
                                list_wdata = in_vtx;
                                n_head     = '0;
                                n_tail     = t_cnt'(1);
                                if (in_mode == MODE_BFS) begin
                                    n_state = S_BFS_POP;
                                end else begin
                                    emit_req = 1'b1;
                                    emit_vtx = in_vtx;
                                    n_state  = S_DFS_STEP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BFS_POP: begin
                if (r_head == r_tail) begin
                    n_state = S_FLUSH;
                end else if (emit_ok) begin
                    emit_req = 1'b1;
                    emit_vtx = r_list[r_head[VTX_W-1:0]];
                    n_cur    = r_list[r_head[VTX_W-1:0]];
                    n_head   = r_head + t_cnt'(1);
                    n_state  = S_BFS_SCAN;
                end
            end
            S_BFS_SCAN: begin
                if (pick.hit) begin
                    list_we    = 1'b1;
                    list_wdata = pick.idx;
                    n_tail     = r_tail + t_cnt'(1);
                    n_visited  = r_visited | (t_row'(1) << pick.idx);
                end else begin
                    n_state = S_BFS_POP;
                end
            end
            S_DFS_STEP: begin
                if (r_tail == '0) begin
                    n_state = S_FLUSH;
                end else if (pick.hit) begin
                    if (emit_ok) begin
                        emit_req   = 1'b1;
                        emit_vtx   = pick.idx;
                        n_visited  = r_visited | (t_row'(1) << pick.idx);
                        list_we    = 1'b1;
                        list_wdata = pick.idx;
                        n_tail     = r_tail + t_cnt'(1);
                    end
                end else begin
                    // No neighbor left: drop the top entry
                    n_tail = r_tail - t_cnt'(1);
                end
            end
            S_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vtx    = r_hold_vtx;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hold one vertex back so the final one can carry tlast
        if (emit_req) begin
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out_vtx   = r_hold_vtx;
                n_out_last  = 1'b0;
            end
            n_hold_valid = 1'b1;
            n_hold_vtx   = emit_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vcount     <= t_cnt'(16);
            r_visited    <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_visited    <= n_visited;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_hold_vtx <= n_hold_vtx;
        r_out_vtx  <= n_out_vtx;
        r_out_last <= n_out_last;
        if (list_we) begin
            r_list[list_waddr] <= list_wdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_vtx};
    assign m_axis_tlast  = r_out_last;

    a_idle_no_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held vertex left over while idle");

    a_head_le_tail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BFS_POP || r_state == S_BFS_SCAN) |-> (r_head <= r_tail))
        else $error("queue head passed tail");

    a_list_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= t_cnt'(LANES))
        else $error("list pointer beyond depth");

    a_flush_has_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_hold_valid)
        else $error("search ended with no vertex emitted");

endmodule

`default_nettype wire
